### sv/lru_recency_tracker_core_defines.svh
// assertion macros for the lru recency tracker checker
// no dependencies; included by the checker file
`ifndef LRU_RECENCY_TRACKER_CORE_DEFINES_SVH
`define LRU_RECENCY_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LRT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define LRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/lrt_pkg.sv
// shared constants and types for the lru recency tracker
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package lrt_pkg;

	localparam int ID_W            = 8;
	localparam int CAP_W           = 3;
	localparam int MAX_ENTRIES_DEF = 4;
	localparam int ID_BITS_DEF     = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = 3'd4;

	// per-request control broadcast along the cell row
	typedef struct packed {
		logic load;
		logic hit;
		logic evict;
	} cell_ctl_t;

endpackage

`default_nettype wire

### sv/lrt_ifs.sv
// valid/ready channel interfaces: request, response and capacity write
// depends on lrt_pkg for field widths
`default_nettype none

interface lrt_req_if;
	logic                      valid;
	logic                      ready;
	logic [lrt_pkg::ID_W-1:0]  item_id;
	modport source (output valid, output item_id, input ready);
	modport sink   (input valid, input item_id, output ready);
endinterface

interface lrt_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic                      evicted;
	logic [lrt_pkg::ID_W-1:0]  evicted_id;
	modport source (output valid, output hit, output evicted, output evicted_id, input ready);
	modport sink   (input valid, input hit, input evicted, input evicted_id, output ready);
endinterface

interface lrt_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [lrt_pkg::CAP_W-1:0] capacity;
	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### sv/lru_recency_tracker_core.sv
// top level of the lru recency tracker: cell row, occupancy, capacity register, response register
// depends on lrt_pkg, lrt_ifs and lrt_cell
`default_nettype none

// Least-recently-used tracker over MAX_ENTRIES ids. Each request references one id; the
// response reports whether it was tracked and which id, if any, was evicted. One request
// is taken per cycle: the compare against every occupied slot is combinational, the shift
// of the cell row toward the old end is registered, and the response sits in an output
// register the cycle after acceptance. A new request is taken whenever that register is
// empty or being drained. Capacity writes are always taken and must only arrive when idle.
module lru_recency_tracker_core #(
	parameter int MAX_ENTRIES = lrt_pkg::MAX_ENTRIES_DEF,
	parameter int ID_BITS     = lrt_pkg::ID_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lrt_req_if.sink   req,
	lrt_rsp_if.source rsp,
	lrt_cfg_if.sink   cfg
);

	localparam int OW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = (OW > lrt_pkg::CAP_W) ? OW : lrt_pkg::CAP_W;

	logic [lrt_pkg::CAP_W-1:0] cap_q;
	logic [OW-1:0]             occ_q;
	logic                      rsp_valid_q;
	logic                      hit_q;
	logic                      evicted_q;
	logic [lrt_pkg::ID_W-1:0]  evicted_id_q;

	logic [EW-1:0]            cap_eff;
	logic                     accept;
	logic                     hit;
	logic                     evict;
	logic [ID_BITS-1:0]       req_id;
	logic [ID_BITS-1:0]       ev_id;
	lrt_pkg::cell_ctl_t       ctl;

	logic [MAX_ENTRIES-1:0]   cell_valid;
	logic [MAX_ENTRIES-1:0]   match_chain;
	logic [ID_BITS-1:0]       slots [MAX_ENTRIES];

	assign req_id    = ID_BITS'(req.item_id);
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// capacity zero acts as one, large values clip to the row length
	always_comb begin
		cap_eff = EW'(cap_q);
		if (cap_q == '0) begin
			cap_eff = EW'(1);
		end
		if (cap_eff > EW'(MAX_ENTRIES)) begin
			cap_eff = EW'(MAX_ENTRIES);
		end
	end

	assign hit   = match_chain[MAX_ENTRIES-1];
	assign evict = !hit && (EW'(occ_q) >= cap_eff);

	assign ctl.load  = accept;
	assign ctl.hit   = hit;
	assign ctl.evict = evict;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
			assign cell_valid[gi] = (occ_q > OW'(gi));
			if (gi == 0) begin : g_head
				lrt_cell #(.ID_BITS(ID_BITS)) u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.req_id     (req_id),
					.prev_id    (req_id),
					.prev_valid (1'b1),
					.valid      (cell_valid[gi]),
					.match_in   (1'b0),
					.slot       (slots[gi]),
					.match_out  (match_chain[gi])
				);
			end else begin : g_body
				lrt_cell #(.ID_BITS(ID_BITS)) u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.req_id     (req_id),
					.prev_id    (slots[gi-1]),
					.prev_valid (cell_valid[gi-1]),
					.valid      (cell_valid[gi]),
					.match_in   (match_chain[gi-1]),
					.slot       (slots[gi]),
					.match_out  (match_chain[gi])
				);
			end
		end
	endgenerate

	// oldest occupied slot
	always_comb begin
		ev_id = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (occ_q == OW'(i + 1)) begin
				ev_id = slots[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= lrt_pkg::CAP_RESET;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.capacity;
			end
			if (accept && !hit && !evict) begin
				occ_q <= occ_q + OW'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q        <= hit;
			evicted_q    <= evict;
			evicted_id_q <= evict ? lrt_pkg::ID_W'(ev_id) : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.evicted    = evicted_q;
	assign rsp.evicted_id = evicted_id_q;

endmodule

`default_nettype wire

### sv/lrt_cell.sv
// one slot of the recency row: holds an id, compares it, takes its neighbour's id on a shift
// depends on lrt_pkg
`default_nettype none

module lrt_cell #(
	parameter int ID_BITS = lrt_pkg::ID_BITS_DEF
) (
	input  wire logic               clk,
	input  wire lrt_pkg::cell_ctl_t ctl,
	input  wire logic [ID_BITS-1:0] req_id,
	input  wire logic [ID_BITS-1:0] prev_id,
	input  wire logic               prev_valid,
	input  wire logic               valid,
	input  wire logic               match_in,
	output logic      [ID_BITS-1:0] slot,
	output logic                    match_out
);

	logic [ID_BITS-1:0] slot_q;
	logic               shift;

	always_comb begin
		if (ctl.hit) begin
			shift = !match_in;
		end else if (ctl.evict) begin
			shift = valid;
		end else begin
			shift = valid || prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && shift) begin
			slot_q <= prev_id;
		end
	end

	assign slot      = slot_q;
	assign match_out = match_in || (valid && (slot_q == req_id));

endmodule

`default_nettype wire

### sv/lrt_checker.sv
// port-level checks for the lru recency tracker, bound to the top level
// depends on lrt_pkg and the assertion macro header
`default_nettype none

`include "lru_recency_tracker_core_defines.svh"

module lrt_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     req_valid,
	input wire logic                     req_ready,
	input wire logic                     rsp_valid,
	input wire logic                     rsp_ready,
	input wire logic                     rsp_hit,
	input wire logic                     rsp_evicted,
	input wire logic [lrt_pkg::ID_W-1:0] rsp_evicted_id
);

	`LRT_ASSERT_NOW(a_hit_no_evict, clk, arst_n, rsp_valid, !(rsp_hit && rsp_evicted), "hit with eviction")
	`LRT_ASSERT_NOW(a_evid_zero, clk, arst_n, rsp_valid && !rsp_evicted, rsp_evicted_id == '0, "evicted id not zero")
	`LRT_ASSERT_NEXT(a_req_rsp, clk, arst_n, req_valid && req_ready, rsp_valid, "no response after request")
	`LRT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_evicted) && $stable(rsp_evicted_id), "stalled response changed")

endmodule

bind lru_recency_tracker_core lrt_checker u_lrt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_evicted    (rsp.evicted),
	.rsp_evicted_id (rsp.evicted_id)
);

`default_nettype wire
